// ===== hw/rtl/pipcr_pkg.sv =====
package pipcr_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int TOL_WIDTH = 16;
	localparam int DIGIT_WIDTH = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_X = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_Y = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE = 2'd2;

	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

	localparam int POS_WIDTH = 2;
	localparam logic [POS_WIDTH-1:0] POS_EXTERIOR = 2'd0;
	localparam logic [POS_WIDTH-1:0] POS_INTERIOR = 2'd1;
	localparam logic [POS_WIDTH-1:0] POS_ON_EDGE = 2'd2;
	localparam logic [POS_WIDTH-1:0] POS_ON_VERTEX = 2'd3;

	// per-edge job control, travels with the coordinate differences
	typedef struct packed {
		logic rs;   // edge straddles the upper line
		logic ls;   // edge straddles the lower line
		logic hit;  // current vertex lies within tolerance of the point
		logic last; // closing edge: emit a result after it
	} job_flags_t;

endpackage

// ===== hw/rtl/pipcr_front.sv =====
module pipcr_front #(
	parameter int COORD_WIDTH = pipcr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic [COORD_WIDTH-1:0]                                vertex_x,
	input  logic [COORD_WIDTH-1:0]                                vertex_y,
	input  logic                                                  last_vertex,
	input  logic                                                  vertex_valid,
	output logic                                                  vertex_stall,
	input  logic [COORD_WIDTH-1:0]                                point_x,
	input  logic [COORD_WIDTH-1:0]                                point_y,
	input  logic [pipcr_pkg::TOL_WIDTH-1:0]                       tolerance,
	output logic                                                  push,
	output pipcr_pkg::job_flags_t                                 push_flags,
	output logic [4*(COORD_WIDTH+1)+pipcr_pkg::TOL_WIDTH-1:0]     push_data,
	input  logic                                                  queue_full
);

	localparam int W = COORD_WIDTH;
	localparam int DW = COORD_WIDTH + 1;
	localparam int TW = pipcr_pkg::TOL_WIDTH;

	logic [W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic started_q, pend_q;
	logic accept;
	logic [W-1:0] cx, cy;
	logic signed [DW-1:0] dxc, dyc, dxp, dyp, tol_s, neg_tol;
	logic abv_c, abv_p, blw_c, blw_p, hit_c, edge_en;

	// the closing edge reuses the datapath with the first vertex as current
	assign cx = pend_q ? first_x_q : vertex_x;
	assign cy = pend_q ? first_y_q : vertex_y;

	assign dxc = $signed({cx[W-1], cx}) - $signed({point_x[W-1], point_x});
	assign dyc = $signed({cy[W-1], cy}) - $signed({point_y[W-1], point_y});
	assign dxp = $signed({prev_x_q[W-1], prev_x_q}) - $signed({point_x[W-1], point_x});
	assign dyp = $signed({prev_y_q[W-1], prev_y_q}) - $signed({point_y[W-1], point_y});

	assign tol_s = $signed({{(DW-TW){1'b0}}, tolerance});
	assign neg_tol = -tol_s;

	assign abv_c = dyc > tol_s;
	assign abv_p = dyp > tol_s;
	assign blw_c = dyc < neg_tol;
	assign blw_p = dyp < neg_tol;
	assign hit_c = (dxc >= neg_tol) && (dxc <= tol_s) && (dyc >= neg_tol) && (dyc <= tol_s);

	assign vertex_stall = pend_q || queue_full;
	assign accept = vertex_valid && !vertex_stall;
	assign edge_en = pend_q || started_q;

	assign push = accept || pend_q;
	assign push_flags.rs = edge_en && (abv_c != abv_p);
	assign push_flags.ls = edge_en && (blw_c != blw_p);
	assign push_flags.hit = !pend_q && hit_c;
	assign push_flags.last = pend_q;
	assign push_data = {dxc, dyc, dxp, dyp, tolerance};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			// drop polygon state once the closing edge is queued
			if (!queue_full) begin
				pend_q <= 1'b0;
				started_q <= 1'b0;
			end
		end else if (accept) begin
			started_q <= 1'b1;
			if (last_vertex) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !pend_q) begin
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
			if (!started_q) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
		end
	end

endmodule

// ===== hw/rtl/pipcr_queue.sv =====
module pipcr_queue #(
	parameter int DATA_WIDTH = 8,
	parameter int DEPTH = pipcr_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DATA_WIDTH-1:0] push_data,
	output logic                  full,
	input  logic                  pop,
	output logic [DATA_WIDTH-1:0] pop_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic do_push, do_pop;

	assign full = count_q == CNTW'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count missed a pop");

endmodule

// ===== hw/rtl/pipcr_back.sv =====
module pipcr_back #(
	parameter int COORD_WIDTH = pipcr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              job_valid,
	input  pipcr_pkg::job_flags_t                             job_flags,
	input  logic [4*(COORD_WIDTH+1)+pipcr_pkg::TOL_WIDTH-1:0] job_data,
	output logic                                              pop,
	output logic [pipcr_pkg::POS_WIDTH-1:0]                   position,
	output logic                                              position_valid,
	input  logic                                              position_stall
);

	localparam int W = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int AW = W + 2;
	localparam int TW = pipcr_pkg::TOL_WIDTH;
	localparam int DIG = pipcr_pkg::DIGIT_WIDTH;
	localparam int ND = (W + 1 + DIG - 1) / DIG;
	localparam int BW = ND * DIG;
	localparam int NW = 2 * W + 4;
	localparam int CW = $clog2(ND + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_ACC = 3'd3;
	localparam logic [2:0] ST_CMP = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [1:0] PH_P1 = 2'd0; // xc * yp
	localparam logic [1:0] PH_P2 = 2'd1; // xp * yc
	localparam logic [1:0] PH_ED = 2'd2; // tolerance * |D|

	logic [2:0] state_q;
	logic [1:0] phase_q;
	logic [CW-1:0] cnt_q;
	pipcr_pkg::job_flags_t flags_q;
	logic signed [DW-1:0] xc_in, yc_in, xp_in, yp_in;
	logic [TW-1:0] tol_in;
	logic signed [DW-1:0] xc_q, yc_q, xp_q, yp_q;
	logic [TW-1:0] tol_q;
	logic signed [AW-1:0] d_q;
	logic signed [AW-1:0] sel_a, sel_b;
	logic [AW-1:0] a_abs, b_abs;
	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic neg_q;
	logic [AW+DIG-1:0] pp_s1;
	logic [NW-1:0] acc_q;
	logic signed [NW-1:0] acc_s, n_q, ed_q, n_plus_ed;
	logic right_q, left_q, hit_q;
	logic [pipcr_pkg::POS_WIDTH-1:0] pos_q, pos_next;
	logic pos_valid_q, slot_free, load_out, any_hit;

	assign {xc_in, yc_in, xp_in, yp_in, tol_in} = job_data;

	assign pop = (state_q == ST_IDLE) && job_valid;

	always_comb begin
		case (phase_q)
			PH_P1: begin
				sel_a = {xc_q[DW-1], xc_q};
				sel_b = {yp_q[DW-1], yp_q};
			end
			PH_P2: begin
				sel_a = {xp_q[DW-1], xp_q};
				sel_b = {yc_q[DW-1], yc_q};
			end
			PH_ED: begin
				sel_a = d_q;
				sel_b = $signed({{(AW-TW){1'b0}}, tol_q});
			end
			default: begin
				sel_a = '0;
				sel_b = '0;
			end
		endcase
	end

	assign a_abs = sel_a[AW-1] ? -sel_a : sel_a;
	assign b_abs = sel_b[AW-1] ? -sel_b : sel_b;

	assign acc_s = acc_q;
	assign n_plus_ed = n_q + ed_q;

	assign any_hit = hit_q || flags_q.hit;
	assign slot_free = !pos_valid_q || !position_stall;
	assign load_out = (state_q == ST_DONE) && flags_q.last && slot_free;

	always_comb begin
		if (any_hit) begin
			pos_next = pipcr_pkg::POS_ON_VERTEX;
		end else if (right_q != left_q) begin
			pos_next = pipcr_pkg::POS_ON_EDGE;
		end else if (right_q) begin
			pos_next = pipcr_pkg::POS_INTERIOR;
		end else begin
			pos_next = pipcr_pkg::POS_EXTERIOR;
		end
	end

	assign position = pos_q;
	assign position_valid = pos_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_P1;
			cnt_q <= '0;
			right_q <= 1'b0;
			left_q <= 1'b0;
			hit_q <= 1'b0;
			pos_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				pos_valid_q <= 1'b1;
			end else if (!position_stall) begin
				pos_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						phase_q <= PH_P1;
						state_q <= (job_flags.rs || job_flags.ls) ? ST_LOAD : ST_DONE;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(ND)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					case (phase_q)
						PH_P1: begin
							phase_q <= PH_P2;
							state_q <= ST_LOAD;
						end
						PH_P2: begin
							phase_q <= PH_ED;
							state_q <= ST_LOAD;
						end
						default: state_q <= ST_CMP;
					endcase
				end
				ST_CMP: begin
					// crossing to the right of +tol, or to the left of -tol
					if (flags_q.rs && (n_q > ed_q)) begin
						right_q <= !right_q;
					end
					if (flags_q.ls && n_plus_ed[NW-1]) begin
						left_q <= !left_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!flags_q.last) begin
						hit_q <= any_hit;
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						right_q <= 1'b0;
						left_q <= 1'b0;
						hit_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			flags_q <= job_flags;
			xc_q <= xc_in;
			yc_q <= yc_in;
			xp_q <= xp_in;
			yp_q <= yp_in;
			tol_q <= tol_in;
			d_q <= $signed({yp_in[DW-1], yp_in}) - $signed({yc_in[DW-1], yc_in});
		end
		if (state_q == ST_LOAD) begin
			a_q <= a_abs;
			b_q <= BW'(b_abs);
			acc_q <= '0;
			// fold the sign of D into each product so N comes out normalized
			neg_q <= (phase_q == PH_ED) ? 1'b0 : (sel_a[AW-1] ^ sel_b[AW-1] ^ d_q[AW-1]);
		end
		if (state_q == ST_MUL) begin
			// one digit of b per cycle, most significant first
			pp_s1 <= (AW+DIG)'(a_q) * (AW+DIG)'(b_q[BW-1 -: DIG]);
			b_q <= b_q << DIG;
			if (cnt_q != '0) begin
				acc_q <= (acc_q << DIG) + NW'(pp_s1);
			end
		end
		if (state_q == ST_ACC) begin
			case (phase_q)
				PH_P1: n_q <= neg_q ? -acc_s : acc_s;
				PH_P2: n_q <= neg_q ? n_q + acc_s : n_q - acc_s;
				default: ed_q <= acc_s;
			endcase
		end
		if (load_out) begin
			pos_q <= pos_next;
		end
	end

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> !right_q && !left_q && !hit_q)
		else $error("polygon state not cleared after result");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> cnt_q <= CW'(ND))
		else $error("digit counter overran");

	a_edge_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (job_flags.rs || job_flags.ls)) |=> state_q == ST_LOAD && phase_q == PH_P1)
		else $error("straddling edge did not start multiplication");

endmodule

// ===== hw/rtl/point_in_polygon_ray_crossing.sv =====
// Point-in-polygon classifier, ray crossing with an absolute tolerance.
// Configuration: write point_x (index 0), point_y (index 1) and tolerance
// (index 2) through cfg_write_en / cfg_index / cfg_data while the block is idle.
// Input channel: one polygon vertex per item on vertex_x / vertex_y, with
// last_vertex set on the final vertex. The front takes one vertex per cycle
// while the queue has room; after the last vertex, vertex_stall stays high until
// the closing edge is queued. Edges wait in a four-entry queue for the back end.
// Back end: it takes a new edge from the queue only when done with the last one.
// An edge that straddles neither tolerance line skips the multiplier; for a
// straddling edge the single shared (COORD_WIDTH+2) x 16 multiplier forms xc*yp,
// xp*yc and tol*|D| in turn, one 16-bit digit per cycle, over the ND =
// ceil((COORD_WIDTH+1)/16) digits of the second factor.
// Output channel: one position item per polygon, shown after the closing edge
// is done and held in an output register while position_stall is high; the
// back end waits there only when a second result is ready before the first
// one is taken. Reset empties the queue, drops any partial polygon and sets
// point_x = point_y = 0, tolerance = 1.
module point_in_polygon_ray_crossing #(
	parameter int COORD_WIDTH = pipcr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write_en,
	input  logic [pipcr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0]                  cfg_data,
	input  logic                                    vertex_valid,
	output logic                                    vertex_stall,
	input  logic [COORD_WIDTH-1:0]                  vertex_x,
	input  logic [COORD_WIDTH-1:0]                  vertex_y,
	input  logic                                    last_vertex,
	output logic                                    position_valid,
	input  logic                                    position_stall,
	output logic [pipcr_pkg::POS_WIDTH-1:0]         position
);

	localparam int PDW = 4 * (COORD_WIDTH + 1) + pipcr_pkg::TOL_WIDTH;
	localparam int QDW = $bits(pipcr_pkg::job_flags_t) + PDW;

	logic [COORD_WIDTH-1:0] point_x_q, point_y_q;
	logic [pipcr_pkg::TOL_WIDTH-1:0] tolerance_q;

	logic push, queue_full, queue_empty, pop;
	pipcr_pkg::job_flags_t push_flags, pop_flags;
	logic [PDW-1:0] push_data, pop_data;
	logic [QDW-1:0] queue_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
			tolerance_q <= pipcr_pkg::TOL_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				pipcr_pkg::CFG_POINT_X: point_x_q <= cfg_data;
				pipcr_pkg::CFG_POINT_Y: point_y_q <= cfg_data;
				pipcr_pkg::CFG_TOLERANCE: tolerance_q <= cfg_data[pipcr_pkg::TOL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	pipcr_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.point_x(point_x_q),
		.point_y(point_y_q),
		.tolerance(tolerance_q),
		.push(push),
		.push_flags(push_flags),
		.push_data(push_data),
		.queue_full(queue_full)
	);

	pipcr_queue #(
		.DATA_WIDTH(QDW),
		.DEPTH(pipcr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_flags, push_data}),
		.full(queue_full),
		.pop(pop),
		.pop_data(queue_out),
		.empty(queue_empty)
	);

	assign {pop_flags, pop_data} = queue_out;

	pipcr_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(!queue_empty),
		.job_flags(pop_flags),
		.job_data(pop_data),
		.pop(pop),
		.position(position),
		.position_valid(position_valid),
		.position_stall(position_stall)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int COORD_W = pipcr_pkg::COORD_WIDTH_DEF;
	localparam int ONE = 65536;
	localparam int MAX_GAP = 18;
	localparam int DRAIN_CYCLES = 128;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int PRESSURE_POLYGONS = 30;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [127:0] exact_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write_en;
	logic [pipcr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic vertex_valid;
	logic vertex_stall;
	logic [COORD_W-1:0] vertex_x;
	logic [COORD_W-1:0] vertex_y;
	logic last_vertex;
	logic position_valid;
	logic position_stall;
	logic [pipcr_pkg::POS_WIDTH-1:0] position;

	// classifier state mirrored by the testbench
	coord_t query_x = '0;
	coord_t query_y = '0;
	logic [pipcr_pkg::TOL_WIDTH-1:0] query_tol = pipcr_pkg::TOL_RESET;
	coord_t first_vx = '0;
	coord_t first_vy = '0;
	coord_t prev_vx = '0;
	coord_t prev_vy = '0;
	logic poly_open = 1'b0;
	logic right_odd = 1'b0;
	logic left_odd = 1'b0;
	logic hit_seen = 1'b0;

	logic [pipcr_pkg::POS_WIDTH-1:0] expected_positions[$];
	logic [pipcr_pkg::POS_WIDTH-1:0] want_position;
	int mismatch_count = 0;
	int vertices_sent = 0;
	int idle_cycles = 0;
	logic sender_steady = 1'b0;
	logic receiver_steady = 1'b0;
	logic long_hold_req = 1'b0;

	point_in_polygon_ray_crossing dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.position_valid(position_valid),
		.position_stall(position_stall),
		.position(position)
	);

	always #1 clk = ~clk;

	function automatic logic vertex_near_point(coord_t vx, coord_t vy);
		exact_t e, dx, dy;
		e = exact_t'({1'b0, query_tol});
		dx = exact_t'(vx) - exact_t'(query_x);
		dy = exact_t'(vy) - exact_t'(query_y);
		return dx >= -e && dx <= e && dy >= -e && dy <= e;
	endfunction

	// c is the current vertex, q the previous one
	function automatic void apply_edge_crossing(coord_t cx, coord_t cy, coord_t qx, coord_t qy);
		exact_t e, xc, yc, xp, yp, n, d;
		logic rs, ls;
		e = exact_t'({1'b0, query_tol});
		xc = exact_t'(cx) - exact_t'(query_x);
		yc = exact_t'(cy) - exact_t'(query_y);
		xp = exact_t'(qx) - exact_t'(query_x);
		yp = exact_t'(qy) - exact_t'(query_y);
		rs = (yc > e) != (yp > e);
		ls = (yc < -e) != (yp < -e);
		if (!rs && !ls)
			return;
		n = xc * yp - xp * yc;
		d = yp - yc;
		if (d == 0)
			return;
		// compare the crossing abscissa n/d without dividing
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		if (rs && n > e * d)
			right_odd = !right_odd;
		if (ls && n < (-e) * d)
			left_odd = !left_odd;
	endfunction

	function automatic void classify_vertex(coord_t vx, coord_t vy, logic last);
		logic [pipcr_pkg::POS_WIDTH-1:0] pos;
		if (vertex_near_point(vx, vy))
			hit_seen = 1'b1;
		if (poly_open) begin
			apply_edge_crossing(vx, vy, prev_vx, prev_vy);
		end else begin
			first_vx = vx;
			first_vy = vy;
			poly_open = 1'b1;
		end
		prev_vx = vx;
		prev_vy = vy;
		if (last) begin
			apply_edge_crossing(first_vx, first_vy, vx, vy);
			if (hit_seen)
				pos = pipcr_pkg::POS_ON_VERTEX;
			else if (right_odd != left_odd)
				pos = pipcr_pkg::POS_ON_EDGE;
			else if (right_odd)
				pos = pipcr_pkg::POS_INTERIOR;
			else
				pos = pipcr_pkg::POS_EXTERIOR;
			expected_positions.push_back(pos);
			first_vx = '0;
			first_vy = '0;
			prev_vx = '0;
			prev_vy = '0;
			poly_open = 1'b0;
			right_odd = 1'b0;
			left_odd = 1'b0;
			hit_seen = 1'b0;
		end
	endfunction

	// signed offset spanning about 2^bits, bits in 1..32
	function automatic logic [31:0] jitter(int bits);
		return 32'($signed($urandom()) >>> (32 - bits));
	endfunction

	task automatic load_config(input logic [31:0] px, input logic [31:0] py,
			input logic [pipcr_pkg::TOL_WIDTH-1:0] tol);
		logic [15:0] junk;
		junk = 16'($urandom());
		cfg_write_en <= 1'b1;
		cfg_index <= pipcr_pkg::CFG_POINT_X;
		cfg_data <= px;
		@(posedge clk);
		cfg_index <= pipcr_pkg::CFG_POINT_Y;
		cfg_data <= py;
		@(posedge clk);
		// upper bits are outside the tolerance register and must be dropped
		cfg_index <= pipcr_pkg::CFG_TOLERANCE;
		cfg_data <= {junk, tol};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		query_x = px;
		query_y = py;
		query_tol = tol;
	endtask

	task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy, input logic last);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_valid <= 1'b1;
		vertex_x <= vx;
		vertex_y <= vy;
		last_vertex <= last;
		@(posedge clk);
		while (vertex_stall) @(posedge clk);
		classify_vertex(vx, vy, last);
		vertices_sent++;
	endtask

	task automatic wait_idle();
		vertex_valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void pick_vertex(input int span, input logic [31:0] last_x,
			input logic [31:0] last_y, output logic [31:0] vx, output logic [31:0] vy);
		int kind, t;
		kind = $urandom_range(0, 11);
		t = query_tol;
		vx = query_x + jitter(span);
		vy = query_y + jitter(span);
		case (kind)
			0: begin
				vx = $urandom();
				vy = $urandom();
			end
			1: begin
				vx = query_x + 32'($urandom_range(0, 2 * t) - t);
				vy = query_y + 32'($urandom_range(0, 2 * t) - t);
			end
			2: begin
				// sit on or next to a tolerance line
				vy = query_y + 32'(($urandom_range(0, 1) ? t : -t) + $urandom_range(0, 2) - 1);
			end
			3: begin
				vx = query_x + 32'(($urandom_range(0, 1) ? t : -t) + $urandom_range(0, 2) - 1);
			end
			4: begin
				vx = last_x;
				vy = last_y;
			end
			5: begin
				vy = last_y;
			end
			default: ;
		endcase
	endfunction

	task automatic send_random_polygon();
		int n, span;
		logic [31:0] vx, vy;
		n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
		span = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(2, 24);
		vx = query_x;
		vy = query_y;
		for (int i = 0; i < n; i++) begin
			pick_vertex(span, vx, vy, vx, vy);
			send_vertex(vx, vy, i == n - 1);
		end
	endtask

	task automatic test_directed();
		// reset values of the registers: point at the origin, tolerance one LSB
		send_vertex(-ONE, -ONE, 1'b0);
		send_vertex(ONE, -ONE, 1'b0);
		send_vertex(ONE, ONE, 1'b0);
		send_vertex(-ONE, ONE, 1'b1);
		send_vertex(2 * ONE, 2 * ONE, 1'b0);
		send_vertex(3 * ONE, 2 * ONE, 1'b0);
		send_vertex(3 * ONE, 3 * ONE, 1'b1);
		send_vertex(0, 0, 1'b0);
		send_vertex(ONE, 0, 1'b0);
		send_vertex(0, ONE, 1'b1);
		send_vertex(0, -ONE, 1'b0);
		send_vertex(2 * ONE, -ONE, 1'b0);
		send_vertex(2 * ONE, ONE, 1'b0);
		send_vertex(0, ONE, 1'b1);
		// single vertex polygons: away from the point, then within tolerance
		send_vertex(5 * ONE, 5 * ONE, 1'b1);
		send_vertex(1, -1, 1'b1);
		wait_idle();
		load_config(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		wait_idle();
		load_config(32'h0, 32'h0, 16'h0);
		send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_backpressure();
		int a;
		load_config(jitter(20), jitter(20), 16'($urandom_range(0, 255)));
		sender_steady = 1'b1;
		long_hold_req = 1'b1;
		// straddling triangles keep the back end slow, so the queue fills
		for (int i = 0; i < PRESSURE_POLYGONS; i++) begin
			a = $urandom_range(ONE, 1 << 22);
			send_vertex(query_x - a, query_y - a, 1'b0);
			send_vertex(query_x + a, query_y - a, 1'b0);
			send_vertex(query_x + jitter(16), query_y + a, 1'b1);
		end
		wait_idle();
		sender_steady = 1'b0;
	endtask

	task automatic test_random_polygons();
		int phase_start;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			sender_steady = (phase == 3);
			receiver_steady = (phase == 3) || (phase == 6);
			case (phase)
				0: load_config(jitter(18), jitter(18), 16'h0);
				1: load_config(jitter(18), jitter(18), 16'hFFFF);
				2: load_config(32'h7FFF_FFFF, 32'h8000_0000, 16'($urandom_range(0, 65535)));
				3: load_config(32'h8000_0000, 32'h7FFF_FFFF, 16'($urandom_range(0, 16)));
				4: load_config($urandom(), $urandom(), 16'($urandom()));
				default: load_config(jitter($urandom_range(1, 32)), jitter($urandom_range(1, 32)),
						16'($urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom()));
			endcase
			phase_start = vertices_sent;
			while (vertices_sent - phase_start < ITEMS_PER_PHASE)
				send_random_polygon();
			wait_idle();
		end
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
	endtask

	// receiver pacing: random hold before each item, one long hold on request
	initial begin : result_pacing
		int hold;
		position_stall <= 1'b0;
		forever begin
			if (long_hold_req) begin
				hold = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end else if (receiver_steady) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, MAX_GAP);
			end
			if (hold > 0) begin
				position_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			position_stall <= 1'b0;
			@(posedge clk);
			while (!position_valid && !long_hold_req) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && position_valid && !position_stall) begin
			if (expected_positions.size() == 0) begin
				$display("%0t: position %0d with no polygon pending", $time, position);
				mismatch_count++;
			end else begin
				want_position = expected_positions.pop_front();
				if (position !== want_position) begin
					$display("%0t: position mismatch, expected %0d, got %0d", $time,
							want_position, position);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vertex_valid && !vertex_stall) || (position_valid && !position_stall) || cfg_write_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no handshake for %0d cycles, %0d results pending", $time,
					idle_cycles, expected_positions.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= pipcr_pkg::CFG_POINT_X;
		cfg_data <= '0;
		vertex_valid <= 1'b0;
		vertex_x <= '0;
		vertex_y <= '0;
		last_vertex <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_polygons();
		wait_idle();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== point_in_polygon_ray_crossing.f =====
hw/rtl/pipcr_pkg.sv
hw/rtl/pipcr_front.sv
hw/rtl/pipcr_queue.sv
hw/rtl/pipcr_back.sv
hw/rtl/point_in_polygon_ray_crossing.sv
tb/sv/tb_top.sv
